@@ rtl/core/hashed_thread_slot_table_assert.svh @@
// assertion macros for the thread slot table checker
// all sample on the rising edge of clock
`ifndef HASHED_THREAD_SLOT_TABLE_ASSERT_SVH
`define HASHED_THREAD_SLOT_TABLE_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define HTS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("thread slot table check failed");

// next-cycle implication, quiet while reset is high
`define HTS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("thread slot table check failed");

// next-cycle implication that also holds across reset
`define HTS_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("thread slot table check failed");

`endif

@@ rtl/core/hts_pkg.sv @@
`timescale 1ns / 1ps

package hts_pkg;

   localparam int CMD_W     = 2;
   localparam int TID_W     = 32;
   localparam int STATUS_W  = 3;
   localparam int SLOT_W    = 14;
   // group index is taken from the identifier without its lowest bit
   localparam int HASH_BITS = TID_W - 1;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam cmd_type CMD_LOOKUP  = 2'd0;
   localparam cmd_type CMD_ALLOC   = 2'd1;
   localparam cmd_type CMD_RELEASE = 2'd2;

   localparam status_type STAT_FOUND     = 3'd0;
   localparam status_type STAT_ALLOC     = 3'd1;
   localparam status_type STAT_RELEASED  = 3'd2;
   localparam status_type STAT_NOT_FOUND = 3'd3;
   localparam status_type STAT_FULL      = 3'd4;

endpackage

@@ rtl/core/hts_tag_ram.sv @@
`timescale 1ns / 1ps

// tag store: one write port, one read port, registered read data
module hts_tag_ram #(
   parameter int DEPTH = 16384,
   parameter int AW    = 14,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/hts_group_hash.sv @@
`timescale 1ns / 1ps

// reduction of the shifted identifier modulo the group count by reciprocal multiplication
// pipeline: operand register, multiply, quotient times group count, subtract
module hts_group_hash #(
   parameter int GROUP_COUNT = 128,
   localparam int GW = $clog2(GROUP_COUNT)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [hts_pkg::HASH_BITS-1:0] value,
   output logic                          done,
   output logic [GW-1:0]                 group
);
   import hts_pkg::*;

   // product width and quotient width
   localparam int PW = 2 * HASH_BITS + 1;
   localparam int QW = PW - HASH_BITS - GW;
   // floor(2^(HASH_BITS+GW) / GROUP_COUNT) + 1, exact for every HASH_BITS-bit operand
   localparam longint unsigned MAGIC_WIDE =
      ((64'd1 << (HASH_BITS + GW)) / 64'(GROUP_COUNT)) + 64'd1;
   localparam logic [HASH_BITS:0] MAGIC = (HASH_BITS + 1)'(MAGIC_WIDE);

   logic [3:0]           vld_ff;
   logic [HASH_BITS-1:0] val_ff;
   logic [PW-1:0]        prod_ff;
   logic [HASH_BITS-1:0] qg_ff;
   logic [GW-1:0]        rem_ff;
   logic [QW-1:0]        quot;
   logic [HASH_BITS-1:0] diff;

   assign quot = prod_ff[PW-1:HASH_BITS+GW];
   assign diff = val_ff - qg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], start};
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         val_ff <= value;
      end
      if (vld_ff[0]) begin
         prod_ff <= PW'(val_ff) * PW'(MAGIC);
      end
      if (vld_ff[1]) begin
         qg_ff <= HASH_BITS'(quot) * HASH_BITS'(GROUP_COUNT);
      end
      if (vld_ff[2]) begin
         // remainder is below the group count
         rem_ff <= diff[GW-1:0];
      end
   end

   assign done  = vld_ff[3];
   assign group = rem_ff;

endmodule

@@ rtl/core/hashed_thread_slot_table.sv @@
`timescale 1ns / 1ps

// Thread slot table. A request (start high while busy is low) carries a command and a
// thread identifier; exactly one result follows, shown for a single cycle with rsp_strobe,
// and the receiver cannot stall it, so it must take the result in that cycle. After reset
// the block runs a clearing pass over all GROUP_COUNT * GROUP_SIZE tags (16384 at the default
// sizes), one tag per cycle, with busy high. A zero identifier is answered the cycle after
// it is taken. Any other request first has its identifier reduced to a group (operand
// register, reciprocal multiply, product with the group count, subtract), then the group
// base is set, then the group is scanned at one slot per cycle through the single read
// port of the tag memory, stopping early on a hit, and last the result is formed, with any
// write-back to the tag memory. busy drops in the cycle the result is shown, so the next
// request can be taken then.
module hashed_thread_slot_table #(
   parameter int GROUP_COUNT = 128,
   parameter int GROUP_SIZE  = 128
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  hts_pkg::cmd_type           req_cmd,
   input  logic [hts_pkg::TID_W-1:0]  req_thread_id,
   output logic                       rsp_strobe,
   output hts_pkg::status_type        rsp_status,
   output logic [hts_pkg::SLOT_W-1:0] rsp_slot_index
);
   import hts_pkg::*;

   localparam int DEPTH = GROUP_COUNT * GROUP_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam int GW    = $clog2(GROUP_COUNT);
   localparam int OFW   = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
   localparam int ICW   = $clog2(GROUP_SIZE + 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   cmd_type           cmd_ff, cmd_in;
   logic [TID_W-1:0]  tid_ff, tid_in;
   logic [AW-1:0]     base_ff, base_in;
   logic [ICW-1:0]    issue_ff, issue_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [OFW-1:0]    chk_off_ff, chk_off_in;
   logic              hit_ff, hit_in;
   logic [OFW-1:0]    hit_off_ff, hit_off_in;
   logic              emp_ff, emp_in;
   logic [OFW-1:0]    emp_off_ff, emp_off_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;

   logic              hash_start;
   logic              hash_done;
   logic [GW-1:0]     group;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [TID_W-1:0]  rd_data;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [TID_W-1:0]  wr_data;
   logic [AW-1:0]     hit_slot;
   logic [AW-1:0]     emp_slot;

   // group index: (thread_id >> 1) mod GROUP_COUNT
   hts_group_hash #(
      .GROUP_COUNT (GROUP_COUNT)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .value (req_thread_id[TID_W-1:1]),
      .done  (hash_done),
      .group (group)
   );

   hts_tag_ram #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (TID_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // absolute slots of the first match and the first empty tag
   assign hit_slot = base_ff + AW'(hit_off_ff);
   assign emp_slot = base_ff + AW'(emp_off_ff);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      cmd_in        = cmd_ff;
      tid_in        = tid_ff;
      base_in       = base_ff;
      issue_in      = issue_ff;
      chk_vld_in    = 1'b0;
      chk_off_in    = chk_off_ff;
      hit_in        = hit_ff;
      hit_off_in    = hit_off_ff;
      emp_in        = emp_ff;
      emp_off_in    = emp_off_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      hash_start    = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = base_ff + AW'(issue_ff);
      wr_en         = 1'b0;
      wr_addr       = clr_addr_ff;
      wr_data       = '0;

      case (state_ff)
         ST_CLEAR: begin
            // clearing pass, one tag per cycle
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (start) begin
               cmd_in = req_cmd;
               tid_in = req_thread_id;
               if (req_thread_id == '0) begin
                  // zero marks an empty slot, so it never matches anything
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_NOT_FOUND;
                  rsp_slot_in   = '0;
               end else begin
                  hash_start = 1'b1;
                  state_in   = ST_HASH;
               end
            end
         end

         ST_HASH: begin
            if (hash_done) begin
               base_in  = AW'(int'(group) * GROUP_SIZE);
               issue_in = '0;
               hit_in   = 1'b0;
               emp_in   = 1'b0;
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // reads issue one slot ahead of the compare
            rd_en = issue_ff < ICW'(GROUP_SIZE);
            if (rd_en) begin
               issue_in = issue_ff + 1'b1;
            end
            chk_vld_in = rd_en;
            chk_off_in = issue_ff[OFW-1:0];
            if (chk_vld_ff) begin
               if (rd_data == tid_ff) begin
                  hit_in     = 1'b1;
                  hit_off_in = chk_off_ff;
                  state_in   = ST_FINISH;
               end else begin
                  if ((rd_data == '0) && !emp_ff) begin
                     emp_in     = 1'b1;
                     emp_off_in = chk_off_ff;
                  end
                  if (chk_off_ff == OFW'(GROUP_SIZE - 1)) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end

         ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            if (cmd_ff == CMD_RELEASE) begin
               if (hit_ff) begin
                  wr_en         = 1'b1;
                  wr_addr       = hit_slot;
                  wr_data       = '0;
                  rsp_status_in = STAT_RELEASED;
                  rsp_slot_in   = SLOT_W'(hit_slot);
               end else begin
                  rsp_status_in = STAT_NOT_FOUND;
                  rsp_slot_in   = '0;
               end
            end else if (hit_ff) begin
               rsp_status_in = STAT_FOUND;
               rsp_slot_in   = SLOT_W'(hit_slot);
            end else if (cmd_ff == CMD_ALLOC) begin
               if (emp_ff) begin
                  // claim the first empty slot seen in the scan
                  wr_en         = 1'b1;
                  wr_addr       = emp_slot;
                  wr_data       = tid_ff;
                  rsp_status_in = STAT_ALLOC;
                  rsp_slot_in   = SLOT_W'(emp_slot);
               end else begin
                  rsp_status_in = STAT_FULL;
                  rsp_slot_in   = '0;
               end
            end else begin
               // lookup miss, unused command code behaves as lookup
               rsp_status_in = STAT_NOT_FOUND;
               rsp_slot_in   = '0;
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         chk_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         cmd_ff        <= cmd_in;
         tid_ff        <= tid_in;
         base_ff       <= base_in;
         issue_ff      <= issue_in;
         chk_vld_ff    <= chk_vld_in;
         chk_off_ff    <= chk_off_in;
         hit_ff        <= hit_in;
         hit_off_ff    <= hit_off_in;
         emp_ff        <= emp_in;
         emp_off_ff    <= emp_off_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
      end
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

endmodule

@@ rtl/core/hts_checker.sv @@
`timescale 1ns / 1ps

`include "hashed_thread_slot_table_assert.svh"

module hts_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_strobe,
   input hts_pkg::status_type        rsp_status,
   input logic [hts_pkg::SLOT_W-1:0] rsp_slot_index
);
   import hts_pkg::*;

   // clearing pass holds requests off after reset
   `HTS_ASSERT_NEXT_ALWAYS(a_reset_busy, reset, busy)

   // a taken request either starts work or is answered at once
   `HTS_ASSERT_NEXT(a_request_progress, start && !busy, busy || rsp_strobe)

   // status stays within its defined codes
   `HTS_ASSERT_NOW(a_status_legal, rsp_strobe, rsp_status <= STAT_FULL)

   // misses and full groups report no slot
   `HTS_ASSERT_NOW(a_miss_slot_zero,
      rsp_strobe && ((rsp_status == STAT_NOT_FOUND) || (rsp_status == STAT_FULL)),
      rsp_slot_index == '0)

endmodule

bind hashed_thread_slot_table hts_checker u_hts_checker (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

// checks the thread slot table against a shadow copy of its tag store;
// every request is predicted at the edge where it is taken, and every strobed
// result is matched, field by field, with the oldest prediction still waiting
module testbench;
   import hts_pkg::*;

   localparam int GROUP_COUNT = 128;
   localparam int GROUP_SIZE  = 128;
   localparam int TABLE_DEPTH = GROUP_COUNT * GROUP_SIZE;
   // slowest correct run is the clearing pass plus ~900 requests with full scans and idle
   // gaps; the limit allows several times that
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int DRAIN_LIMIT = 5000;
   localparam int TAIL_CYCLES = 200;
   // the fourth command code has no name in the package and acts as a lookup
   localparam cmd_type CMD_SPARE = 2'd3;

   typedef struct packed {
      status_type         status;
      logic [SLOT_W-1:0]  slot;
   } slot_result_type;

   // one row of the directed part; typed rows carry their own answer
   typedef struct packed {
      cmd_type            cmd;
      logic [TID_W-1:0]   tid;
      logic               typed;
      status_type         status;
      logic [SLOT_W-1:0]  slot;
   } request_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   cmd_type             req_cmd;
   logic [TID_W-1:0]    req_thread_id;
   logic                rsp_strobe;
   status_type          rsp_status;
   logic [SLOT_W-1:0]   rsp_slot_index;

   hashed_thread_slot_table #(
      .GROUP_COUNT(GROUP_COUNT),
      .GROUP_SIZE (GROUP_SIZE)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_thread_id (req_thread_id),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_slot_index(rsp_slot_index)
   );

   // shadow of the tag store, zero means the slot is empty
   logic [TID_W-1:0] tag_shadow [TABLE_DEPTH];
   // predictions waiting for their strobe, oldest first
   slot_result_type  pending_results [$];
   // identifiers that the random part draws from, so that lookups and releases hit
   logic [TID_W-1:0] id_pool [$];
   int               errors = 0;
   int unsigned      cycle_count = 0;

   // directed part: empty table after reset, extreme identifiers, zero identifier,
   // the spare command, release miss, reuse of a freed slot
   request_row_type directed_rows [23] = '{
      '{CMD_LOOKUP,  32'h0000_0001, 1'b1, STAT_NOT_FOUND, 14'h0000},
      '{CMD_RELEASE, 32'hFFFF_FFFF, 1'b1, STAT_NOT_FOUND, 14'h0000},
      '{CMD_LOOKUP,  32'h0000_0000, 1'b1, STAT_NOT_FOUND, 14'h0000},
      '{CMD_ALLOC,   32'h0000_0000, 1'b1, STAT_NOT_FOUND, 14'h0000},
      '{CMD_ALLOC,   32'hFFFF_FFFF, 1'b1, STAT_ALLOC,     14'h3F80},
      '{CMD_LOOKUP,  32'hFFFF_FFFF, 1'b1, STAT_FOUND,     14'h3F80},
      '{CMD_SPARE,   32'hFFFF_FFFF, 1'b1, STAT_FOUND,     14'h3F80},
      '{CMD_ALLOC,   32'h0000_0001, 1'b1, STAT_ALLOC,     14'h0000},
      '{CMD_ALLOC,   32'h0000_0101, 1'b0, STAT_FOUND,     14'h0000},
      '{CMD_ALLOC,   32'h8000_0000, 1'b0, STAT_FOUND,     14'h0000},
      '{CMD_RELEASE, 32'h0000_0001, 1'b1, STAT_RELEASED,  14'h0000},
      '{CMD_ALLOC,   32'h8000_0001, 1'b0, STAT_FOUND,     14'h0000},
      '{CMD_SPARE,   32'h0000_0002, 1'b0, STAT_FOUND,     14'h0000},
      '{CMD_LOOKUP,  32'h0000_0002, 1'b0, STAT_FOUND,     14'h0000},
      '{CMD_RELEASE, 32'h8000_0000, 1'b0, STAT_FOUND,     14'h0000},
      '{CMD_RELEASE, 32'h8000_0000, 1'b1, STAT_NOT_FOUND, 14'h0000},
      '{CMD_ALLOC,   32'hAAAA_AAAA, 1'b0, STAT_FOUND,     14'h0000},
      '{CMD_ALLOC,   32'h5555_5555, 1'b0, STAT_FOUND,     14'h0000},
      '{CMD_RELEASE, 32'hFFFF_FFFF, 1'b1, STAT_RELEASED,  14'h3F80},
      '{CMD_LOOKUP,  32'hFFFF_FFFF, 1'b1, STAT_NOT_FOUND, 14'h0000},
      '{CMD_RELEASE, 32'h0000_0000, 1'b1, STAT_NOT_FOUND, 14'h0000},
      '{CMD_SPARE,   32'h0000_0000, 1'b1, STAT_NOT_FOUND, 14'h0000},
      '{CMD_ALLOC,   32'hFFFF_FFFE, 1'b0, STAT_FOUND,     14'h0000}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // works out the answer to one request and applies it to the shadow store
   function automatic slot_result_type predict_slot_result(cmd_type cmd,
                                                           logic [TID_W-1:0] tid);
      slot_result_type res;
      int unsigned     base;
      int              hit_slot;
      int              free_slot;
      int              i;
      res.status = STAT_NOT_FOUND;
      res.slot   = '0;
      // zero identifier is turned away and leaves the store alone
      if (tid == '0)
         return res;
      base      = ((tid >> 1) % GROUP_COUNT) * GROUP_SIZE;
      hit_slot  = -1;
      free_slot = -1;
      for (i = 0; i < GROUP_SIZE; i++) begin
         if (hit_slot < 0 && tag_shadow[base + i] == tid)
            hit_slot = base + i;
         if (free_slot < 0 && tag_shadow[base + i] == '0)
            free_slot = base + i;
      end
      if (cmd == CMD_RELEASE) begin
         // a release miss reports not found and changes nothing
         if (hit_slot >= 0) begin
            tag_shadow[hit_slot] = '0;
            res.status = STAT_RELEASED;
            res.slot   = SLOT_W'(hit_slot);
         end
      end else if (hit_slot >= 0) begin
         res.status = STAT_FOUND;
         res.slot   = SLOT_W'(hit_slot);
      end else if (cmd == CMD_ALLOC) begin
         // miss claims the first empty slot, or the group is full
         if (free_slot >= 0) begin
            tag_shadow[free_slot] = tid;
            res.status = STAT_ALLOC;
            res.slot   = SLOT_W'(free_slot);
         end else begin
            res.status = STAT_FULL;
         end
      end
      // lookup and the spare command on a miss fall through as not found
      return res;
   endfunction

   // drives one request, holds it until the block takes it, then files the
   // expected answer; typed rows use their own answer but still update the shadow
   task automatic issue_request(cmd_type cmd, logic [TID_W-1:0] tid, logic typed,
                                status_type typed_status, logic [SLOT_W-1:0] typed_slot);
      slot_result_type predicted;
      slot_result_type typed_res;
      req_cmd       <= cmd;
      req_thread_id <= tid;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      predicted = predict_slot_result(cmd, tid);
      typed_res.status = typed_status;
      typed_res.slot   = typed_slot;
      pending_results.push_back(typed ? typed_res : predicted);
   endtask

   // sender now and then drops start and idles for a randomly drawn stretch
   task automatic pause_sender(bit allow);
      int n;
      if (allow && $urandom_range(0, 99) < 35) begin
         n = $urandom_range(1, 9);
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // random identifier that hashes into the given group
   function automatic logic [TID_W-1:0] id_in_group(int unsigned grp);
      logic [TID_W-1:0] tid;
      tid      = $urandom();
      tid[7:1] = grp[6:0];
      if (tid == '0)
         tid = 32'h0000_0001;
      return tid;
   endfunction

   // one random request: command by weight, identifier mostly from the pool,
   // sometimes zero or fully random noise
   task automatic random_request(int alloc_pct, int lookup_pct, int release_pct, int noise_pct);
      cmd_type          cmd;
      logic [TID_W-1:0] tid;
      int               roll;
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct)
         cmd = CMD_ALLOC;
      else if (roll < alloc_pct + lookup_pct)
         cmd = CMD_LOOKUP;
      else if (roll < alloc_pct + lookup_pct + release_pct)
         cmd = CMD_RELEASE;
      else
         cmd = CMD_SPARE;
      roll = $urandom_range(0, 99);
      if (roll < 2)
         tid = '0;
      else if (roll < noise_pct)
         tid = $urandom();
      else
         tid = id_pool[$urandom_range(0, id_pool.size() - 1)];
      issue_request(cmd, tid, 1'b0, STAT_FOUND, '0);
   endtask

   // result checker: the receiver cannot stall, so every strobe is taken
   always @(posedge clock) begin : result_check
      slot_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none actual status %0d slot %0d",
                     $time, rsp_status, rsp_slot_index);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
            end
            if (rsp_slot_index !== want.slot) begin
               errors++;
               $display("%0t: slot_index expected %0d actual %0d",
                        $time, want.slot, rsp_slot_index);
            end
         end
      end
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      int          k;
      int          drain;
      int unsigned fill_group;
      int unsigned hot_group;
      bit          idle_enabled;
      logic [TID_W-1:0] tid;

      start         = 1'b0;
      reset         = 1'b1;
      req_cmd       = CMD_LOOKUP;
      req_thread_id = '0;
      foreach (tag_shadow[i])
         tag_shadow[i] = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed rows; the first one also waits out the clearing pass
      foreach (directed_rows[i]) begin
         issue_request(directed_rows[i].cmd, directed_rows[i].tid, directed_rows[i].typed,
                       directed_rows[i].status, directed_rows[i].slot);
         pause_sender(1'b1);
      end

      // mixed traffic over three hot groups: the first, the last and one at random
      hot_group = $urandom_range(1, GROUP_COUNT - 2);
      for (k = 0; k < 16; k++) begin
         id_pool.push_back(id_in_group(0));
         id_pool.push_back(id_in_group(GROUP_COUNT - 1));
         id_pool.push_back(id_in_group(hot_group));
      end
      idle_enabled = 1'b1;
      for (k = 0; k < 300; k++) begin
         if (k % 40 == 0)
            idle_enabled = ($urandom_range(0, 2) != 0);
         random_request(40, 30, 22, 12);
         pause_sender(idle_enabled);
      end

      // fill one group past its size so that it runs full, with lookups mixed in
      // (misses in a full group cost the longest scan)
      fill_group = $urandom_range(0, GROUP_COUNT - 1);
      for (k = 0; k < 200; k++) begin
         if (k % 40 == 0)
            idle_enabled = ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 99) < 80) begin
            tid = id_in_group(fill_group);
            id_pool.push_back(tid);
            issue_request(CMD_ALLOC, tid, 1'b0, STAT_FOUND, '0);
         end else if ($urandom_range(0, 1) == 0) begin
            issue_request(CMD_LOOKUP, id_pool[$urandom_range(0, id_pool.size() - 1)],
                          1'b0, STAT_FOUND, '0);
         end else begin
            issue_request(CMD_LOOKUP, id_in_group(fill_group), 1'b0, STAT_FOUND, '0);
         end
         pause_sender(idle_enabled);
      end

      // punch holes with releases, then refill them; the tail runs without idling
      for (k = 0; k < 420; k++) begin
         if (k % 40 == 0)
            idle_enabled = ($urandom_range(0, 2) != 0);
         if (k < 200)
            random_request(15, 25, 50, 8);
         else
            random_request(50, 25, 15, 8);
         pause_sender(idle_enabled && k < 320);
      end
      start <= 1'b0;

      // let the last request come back, then watch for stray strobes
      drain = 0;
      while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         errors++;
         $display("%0t: results outstanding expected 0 actual %0d",
                  $time, pending_results.size());
      end

      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
